// File: rtl/core/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants and codes for the page bitmap next-fit allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int NUM_PAGES_DEF    = 8192;
  localparam int KERNEL_PAGES_DEF = 4096;

  localparam int WORD_W  = 32;   // pages per memory row
  localparam int WORD_LG = 5;
  localparam int POS_W   = 16;   // page positions and run ends
  localparam int CNT_W   = 14;
  localparam int PAGE_W  = 13;
  localparam int STAT_W  = 2;
  localparam int TOTAL_MAX = 16383;

  localparam logic [CNT_W-1:0] TOTAL_RESET = 14'd8192;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT  = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADARG = 2'd2;

endpackage

// File: rtl/core/pba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_req_if
// Request channel: allocate or free a run of pages.
// ----------------------------------------------------------------------------
interface pba_req_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [pba_pkg::CNT_W-1:0]  page_count;
  logic [pba_pkg::CNT_W-1:0]  align_pages;
  logic [pba_pkg::PAGE_W-1:0] first_page;

  modport source (output valid, output func, output page_count, output align_pages,
                  output first_page, input ready);
  modport sink (input valid, input func, input page_count, input align_pages,
                input first_page, output ready);
endinterface

// File: rtl/core/pba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_rsp_if
// Response channel: status and start page of one request.
// ----------------------------------------------------------------------------
interface pba_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [pba_pkg::STAT_W-1:0] status;
  logic [pba_pkg::PAGE_W-1:0] start_page;

  modport source (output valid, output status, output start_page, input ready);
  modport sink (input valid, input status, input start_page, output ready);
endinterface

// File: rtl/core/page_bitmap_next_fit_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_next_fit_allocator_top
// Used/free bitmap page allocator with a next-fit pointer.
//
// req carries one transaction per request: func selects allocate or free,
// page_count, align_pages (0 means 1) and first_page (free only). rsp returns
// status and start_page, exactly one transaction per request, in order.
// total_pages is written through cfg_we/cfg_wdata while the block is idle,
// a rule the user keeps: the block itself does not enforce it. The bitmap
// sits in one memory of NUM_PAGES/32 rows of 32 pages each. After rst the
// block sweeps every memory row to mark the kernel pages used, with req.ready
// low; cfg writes are still taken.
// Work per request: a zero count or bad free range goes straight to the
// finish state. A free reads and then writes each touched row. An allocation
// reads and checks each row scanned and tests each candidate start, rounds
// each candidate up when align_pages exceeds 1 (16 bit-serial remainder steps
// and a fix-up), and then reads and writes each row marked. One request is in
// work at a time; the next one is taken as soon as the result sits in the
// output register, and a stalled rsp holds the finished result and the block
// waits only to hand over the following one.
// ----------------------------------------------------------------------------
module page_bitmap_next_fit_allocator_top #(
  parameter int unsigned NUM_PAGES    = pba_pkg::NUM_PAGES_DEF,
  parameter int unsigned KERNEL_PAGES = pba_pkg::KERNEL_PAGES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  pba_req_if.sink                   req,
  pba_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [pba_pkg::CNT_W-1:0] cfg_wdata
);

  localparam int W     = pba_pkg::WORD_W;
  localparam int WL    = pba_pkg::WORD_LG;
  localparam int PW    = pba_pkg::POS_W;
  localparam int CW    = pba_pkg::CNT_W;
  localparam int PGW   = pba_pkg::PAGE_W;
  localparam int ROWS  = (NUM_PAGES + W - 1) / W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KEFF  = (KERNEL_PAGES > NUM_PAGES) ? NUM_PAGES : KERNEL_PAGES;
  localparam int KFULL = KEFF / W;
  localparam int KREM  = KEFF % W;
  localparam int NCAP  = (NUM_PAGES > pba_pkg::TOTAL_MAX) ? pba_pkg::TOTAL_MAX : NUM_PAGES;
  localparam logic [PGW-1:0] PTR_RESET = PGW'(KERNEL_PAGES - 1);
  localparam logic [W-1:0]   ONES = '1;

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROUND = 4'd2;
  localparam logic [3:0] S_RFIX  = 4'd3;
  localparam logic [3:0] S_FIT   = 4'd4;
  localparam logic [3:0] S_SRD   = 4'd5;
  localparam logic [3:0] S_SCHK  = 4'd6;
  localparam logic [3:0] S_MRD   = 4'd7;
  localparam logic [3:0] S_MWR   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]       state;
  logic [ROW_W-1:0] init_row;
  logic [PGW-1:0]   ptr;
  logic [CW-1:0]    total_pages;
  logic [CW-1:0]    op_cnt;
  logic [CW-1:0]    op_align;
  logic             win;
  logic [PW-1:0]    win_end;
  logic [PW-1:0]    idx;
  logic [PW-1:0]    p;
  logic [PW-1:0]    stop;
  logic             mark_val;
  logic [PW-1:0]    div_v;
  logic [PW-1:0]    div_sh;
  logic [CW-1:0]    div_rem;
  logic [3:0]       div_cnt;
  logic [1:0]       res_status;
  logic [PGW-1:0]   res_start;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [PGW-1:0]   out_start;
  logic [W-1:0]     rd_data;

  logic [W-1:0]     page_mem [ROWS];

  logic [PW-1:0]    bound;
  logic [PW-1:0]    row_base;
  logic [PW-1:0]    row_end;
  logic             seg_full;
  logic [PW-1:0]    seg_end;
  logic [W-1:0]     seg_mask;
  logic [W-1:0]     used;
  logic [WL-1:0]    used_idx;
  logic [PW-1:0]    hit_next;
  logic [PW-1:0]    fit_end;
  logic [PW-1:0]    e2;
  logic [PW-1:0]    free_end;
  logic [CW-1:0]    align_in;
  logic [PW-1:0]    ptr_next;
  logic [CW:0]      rem_sh;
  logic [CW-1:0]    rem_new;
  logic             mem_we;
  logic [ROW_W-1:0] mem_addr;
  logic [W-1:0]     mem_wdata;
  logic [W-1:0]     init_word;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.start_page = out_start;

  always_comb begin
    if ({2'b00, total_pages} < PW'(NCAP)) begin
      bound = {2'b00, total_pages};
    end else begin
      bound = PW'(NCAP);
    end
  end

  assign row_base = {p[PW-1:WL], {WL{1'b0}}};
  assign row_end  = row_base + PW'(W);
  assign seg_full = (stop >= row_end);
  assign seg_end  = seg_full ? row_end : stop;
  assign seg_mask = (ONES << p[WL-1:0]) & (seg_full ? ONES : ~(ONES << stop[WL-1:0]));
  assign used     = rd_data & seg_mask;

  always_comb begin
    used_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (used[i]) begin
        used_idx = WL'(i);
      end
    end
  end

  assign hit_next = row_base + {{(PW-WL){1'b0}}, used_idx} + PW'(1);
  assign fit_end  = idx + {2'b00, op_cnt};
  assign e2       = ({3'b000, ptr} < bound) ? {3'b000, ptr} : bound;
  assign free_end = {3'b000, req.first_page} + {2'b00, req.page_count};
  assign align_in = (req.align_pages == '0) ? CW'(1) : req.align_pages;
  assign ptr_next = {3'b000, ptr} + PW'(1);

  assign rem_sh  = {div_rem, div_sh[PW-1]};
  assign rem_new = (rem_sh >= {1'b0, op_align}) ? CW'(rem_sh - {1'b0, op_align})
                                                : rem_sh[CW-1:0];

  always_comb begin
    if (int'(init_row) < KFULL) begin
      init_word = ONES;
    end else if (int'(init_row) == KFULL) begin
      init_word = ~(ONES << KREM);
    end else begin
      init_word = '0;
    end
  end

  assign mem_we    = (state == S_INIT) || (state == S_MWR);
  assign mem_addr  = (state == S_INIT) ? init_row : ROW_W'(p >> WL);
  assign mem_wdata = (state == S_INIT) ? init_word
                   : (mark_val ? (rd_data | seg_mask) : (rd_data & ~seg_mask));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_mem[mem_addr] <= mem_wdata;
    end
    rd_data <= page_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= pba_pkg::TOTAL_RESET;
    end else if (cfg_we) begin
      total_pages <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      init_row  <= '0;
      ptr       <= PTR_RESET;
      out_valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_row <= init_row + ROW_W'(1);
          if (init_row == ROW_W'(ROWS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req.valid) begin
            op_cnt     <= req.page_count;
            op_align   <= align_in;
            win        <= 1'b0;
            win_end    <= bound;
            res_start  <= '0;
            if (req.page_count == '0) begin
              res_status <= pba_pkg::ST_BADARG;
              state      <= S_FIN;
            end else if (req.func == pba_pkg::FUNC_FREE) begin
              if (free_end > bound) begin
                res_status <= pba_pkg::ST_BADARG;
                state      <= S_FIN;
              end else begin
                res_status <= pba_pkg::ST_OK;
                p          <= {3'b000, req.first_page};
                stop       <= free_end;
                mark_val   <= 1'b0;
                state      <= S_MRD;
              end
            end else if (align_in == CW'(1)) begin
              res_status <= pba_pkg::ST_OK;
              idx        <= ptr_next;
              state      <= S_FIT;
            end else begin
              res_status <= pba_pkg::ST_OK;
              div_v      <= ptr_next;
              div_sh     <= ptr_next;
              div_rem    <= '0;
              div_cnt    <= 4'(PW - 1);
              state      <= S_ROUND;
            end
          end
        end
        S_ROUND: begin
          div_rem <= rem_new;
          div_sh  <= div_sh << 1;
          div_cnt <= div_cnt - 4'd1;
          if (div_cnt == '0) begin
            state <= S_RFIX;
          end
        end
        S_RFIX: begin
          if (div_rem == '0) begin
            idx <= div_v;
          end else begin
            idx <= div_v + {2'b00, op_align} - {2'b00, div_rem};
          end
          state <= S_FIT;
        end
        S_FIT: begin
          if (fit_end <= win_end) begin
            p     <= idx;
            stop  <= fit_end;
            state <= S_SRD;
          end else if (!win) begin
            win     <= 1'b1;
            win_end <= e2;
            idx     <= '0;
          end else begin
            res_status <= pba_pkg::ST_NOFIT;
            state      <= S_FIN;
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          if (used == '0) begin
            if (seg_end == stop) begin
              res_start <= idx[PGW-1:0];
              ptr       <= PGW'(stop - PW'(1));
              p         <= idx;
              mark_val  <= 1'b1;
              state     <= S_MRD;
            end else begin
              p     <= row_end;
              state <= S_SRD;
            end
          end else if (op_align == CW'(1)) begin
            idx   <= hit_next;
            state <= S_FIT;
          end else begin
            div_v   <= hit_next;
            div_sh  <= hit_next;
            div_rem <= '0;
            div_cnt <= 4'(PW - 1);
            state   <= S_ROUND;
          end
        end
        S_MRD: begin
          state <= S_MWR;
        end
        S_MWR: begin
          p <= seg_end;
          if (seg_end == stop) begin
            state <= S_FIN;
          end else begin
            state <= S_MRD;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_start  <= res_start;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE)
    else $error("accepted transaction did not start work");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_INIT || state == S_MWR))
    else $error("bitmap written outside init or mark");

  a_scan_inside: assert property (@(posedge clk) disable iff (rst)
    state == S_SCHK |-> p < stop)
    else $error("scan position past run end");

  a_mark_inside: assert property (@(posedge clk) disable iff (rst)
    state == S_MWR |-> (p < seg_end && seg_end <= stop))
    else $error("mark segment outside run");

  a_div_align: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND |-> op_align > CW'(1))
    else $error("remainder unit run for unit alignment");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for page_bitmap_next_fit_allocator_top. A shadow page
// map with its own next-fit pointer predicts the status and start page of
// every request. Each accepted reply is compared in order. Directed requests
// cover zero counts, oversized runs, out-of-range frees, kernel page release
// and search wrap. Random alloc/free traffic follows, under several
// total_pages settings, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [pba_pkg::STAT_W-1:0] status;
    logic [pba_pkg::PAGE_W-1:0] start_page;
  } reply_t;

  typedef struct {
    int unsigned first;
    int unsigned count;
  } run_t;

  class page_pool_mirror;
    bit          used[pba_pkg::NUM_PAGES_DEF];
    int unsigned alloc_tail;
    int unsigned total_pages;
    int unsigned failures;
    reply_t      awaited[$];

    function new();
      for (int i = 0; i < pba_pkg::NUM_PAGES_DEF; i++)
        used[i] = (i < pba_pkg::KERNEL_PAGES_DEF);
      alloc_tail = (pba_pkg::KERNEL_PAGES_DEF - 1) & 32'h1fff;
      total_pages = 32'(pba_pkg::TOTAL_RESET);
      failures = 0;
    endfunction

    function int unsigned page_limit();
      return (total_pages > pba_pkg::NUM_PAGES_DEF) ? pba_pkg::NUM_PAGES_DEF : total_pages;
    endfunction

    function int unsigned round_up(int unsigned v, int unsigned a);
      return ((v + a - 1) / a) * a;
    endfunction

    // first aligned free run of cnt pages inside [lo, hi)
    function bit find_free_run(int unsigned lo, int unsigned hi, int unsigned cnt,
                               int unsigned a, output int unsigned found);
      int unsigned idx;
      int unsigned p;
      found = 0;
      idx = round_up(lo, a);
      while (idx + cnt <= hi) begin
        p = idx;
        while (p < idx + cnt && !used[p]) p++;
        if (p == idx + cnt) begin
          found = idx;
          return 1'b1;
        end
        idx = round_up(p + 1, a);
      end
      return 1'b0;
    endfunction

    function reply_t note_request(logic fn, int unsigned cnt, int unsigned align,
                                  int unsigned first);
      reply_t      r;
      int unsigned lim;
      int unsigned a;
      int unsigned hi2;
      int unsigned found;
      bit          ok;
      lim = page_limit();
      a = (align == 0) ? 1 : align;
      r.status = pba_pkg::ST_OK;
      r.start_page = '0;
      if (cnt == 0) begin
        r.status = pba_pkg::ST_BADARG;
      end else if (fn == pba_pkg::FUNC_ALLOC) begin
        ok = find_free_run(alloc_tail + 1, lim, cnt, a, found);
        if (!ok) begin
          hi2 = (alloc_tail < lim) ? alloc_tail : lim;
          ok = find_free_run(0, hi2, cnt, a, found);
        end
        if (ok) begin
          for (int unsigned i = 0; i < cnt; i++) used[found + i] = 1'b1;
          alloc_tail = (found + cnt - 1) & 32'h1fff;
          r.start_page = found[pba_pkg::PAGE_W-1:0];
        end else begin
          r.status = pba_pkg::ST_NOFIT;
        end
      end else if (first + cnt > lim) begin
        r.status = pba_pkg::ST_BADARG;
      end else begin
        for (int unsigned i = 0; i < cnt; i++) used[first + i] = 1'b0;
      end
      awaited.push_back(r);
      return r;
    endfunction

    function void check_reply(logic [pba_pkg::STAT_W-1:0] st,
                              logic [pba_pkg::PAGE_W-1:0] sp);
      reply_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected reply: status %0d start_page %0d", st, sp);
        return;
      end
      want = awaited.pop_front();
      if (st !== want.status || sp !== want.start_page) begin
        failures++;
        if (failures <= 10)
          $display("reply mismatch: expected status %0d start_page %0d, %s %0d %s %0d",
                   want.status, want.start_page, "got status", st, "start_page", sp);
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [pba_pkg::CNT_W-1:0] cfg_wdata;
  pba_req_if                 req();
  pba_rsp_if                 rsp();
  page_pool_mirror           pool;
  run_t                      held_runs[$];
  bit                        steady;

  page_bitmap_next_fit_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // called and returns at a falling edge; valid is left high for the caller
  task automatic issue(logic fn, int unsigned cnt, int unsigned align, int unsigned first);
    reply_t r;
    run_t   held;
    while (!steady && $urandom_range(0, 99) < 38) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.func = fn;
    req.page_count = cnt[pba_pkg::CNT_W-1:0];
    req.align_pages = align[pba_pkg::CNT_W-1:0];
    req.first_page = first[pba_pkg::PAGE_W-1:0];
    do @(posedge clk); while (!req.ready);
    r = pool.note_request(fn, cnt, align, first);
    if (fn == pba_pkg::FUNC_ALLOC && r.status == pba_pkg::ST_OK) begin
      held.first = 32'(r.start_page);
      held.count = cnt;
      held_runs.push_back(held);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    req.valid = 1'b0;
    while (pool.awaited.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_total(int unsigned v);
    cfg_we = 1'b1;
    cfg_wdata = v[pba_pkg::CNT_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    pool.total_pages = v;
  endtask

  task automatic random_item();
    int unsigned roll;
    int unsigned k;
    int unsigned lim;
    int unsigned cnt;
    int unsigned align;
    int unsigned first;
    int unsigned pick;
    run_t        held;
    lim = pool.page_limit();
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (k < 60) align = $urandom_range(0, 1);
    else if (k < 85) align = 1 << $urandom_range(6, 13);
    else if (k < 97) align = $urandom_range(64, 8192);
    else align = $urandom_range(2, 63);
    k = $urandom_range(0, 99);
    if (k < 88) cnt = $urandom_range(1, 64);
    else if (k < 98) cnt = $urandom_range(65, 1024);
    else cnt = $urandom_range(1025, 8192);
    first = $urandom_range(0, 8191);
    if (roll < 80 && roll >= 45 && held_runs.size() != 0) begin
      pick = $urandom_range(0, held_runs.size() - 1);
      held = held_runs[pick];
      held_runs.delete(pick);
      issue(pba_pkg::FUNC_FREE, held.count, align, held.first);
    end else if (roll < 80) begin
      issue(pba_pkg::FUNC_ALLOC, cnt, align, first);
    end else if (roll < 88) begin
      if ($urandom_range(0, 3) != 0) first = $urandom_range(0, lim - 1);
      issue(pba_pkg::FUNC_FREE, $urandom_range(1, 512), align, first);
    end else if (roll < 92) begin
      issue(1'($urandom_range(0, 1)), 0, align, first);
    end else if (roll < 96) begin
      issue(pba_pkg::FUNC_ALLOC, $urandom_range(lim / 2 + 1, 8192), align, first);
    end else begin
      // bulk release keeps the map from filling up
      first = $urandom_range(0, lim - 1);
      issue(pba_pkg::FUNC_FREE, $urandom_range(1, lim - first), align, first);
    end
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = steady || ($urandom_range(0, 99) >= 38);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) pool.check_reply(rsp.status, rsp.start_page);
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    pool = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.func = pba_pkg::FUNC_ALLOC;
    req.page_count = '0;
    req.align_pages = '0;
    req.first_page = '0;
    steady = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_total(32'(pba_pkg::TOTAL_RESET));

    issue(pba_pkg::FUNC_ALLOC, 0, 0, 0);
    issue(pba_pkg::FUNC_FREE, 0, 8192, 8191);
    issue(pba_pkg::FUNC_ALLOC, 1, 0, 8191);
    issue(pba_pkg::FUNC_ALLOC, 8192, 1, 0);
    issue(pba_pkg::FUNC_ALLOC, 3, 8, 0);
    issue(pba_pkg::FUNC_ALLOC, 16, 8192, 0);
    issue(pba_pkg::FUNC_FREE, 2, 0, 8191);
    issue(pba_pkg::FUNC_FREE, 1, 0, 8191);
    issue(pba_pkg::FUNC_FREE, 4096, 0, 0);
    issue(pba_pkg::FUNC_ALLOC, 100, 8192, 0);
    issue(pba_pkg::FUNC_ALLOC, 4096, 4096, 0);
    issue(pba_pkg::FUNC_FREE, 8192, 0, 0);
    issue(pba_pkg::FUNC_ALLOC, 8192, 0, 0);
    issue(pba_pkg::FUNC_ALLOC, 7000, 3, 0);
    issue(pba_pkg::FUNC_ALLOC, 1, 8191, 0);
    issue(pba_pkg::FUNC_ALLOC, 5, 0, 0);
    issue(pba_pkg::FUNC_ALLOC, 40, 5461, 0);
    issue(pba_pkg::FUNC_FREE, 5461, 0, 2730);
    issue(pba_pkg::FUNC_ALLOC, 2730, 2730, 0);
    issue(pba_pkg::FUNC_FREE, 8192, 0, 0);

    for (int n = 0; n < 260; n++) random_item();
    settle();
    write_total(1);
    for (int n = 0; n < 40; n++) random_item();
    settle();
    write_total($urandom_range(2, 8191));
    for (int n = 0; n < 200; n++) random_item();
    settle();
    write_total(32'(pba_pkg::TOTAL_RESET));
    steady = 1'b1;
    for (int n = 0; n < 300; n++) begin
      if (n == 120) steady = 1'b0;
      random_item();
    end
    settle();
    repeat (20) @(posedge clk);
    if (pool.failures == 0 && pool.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pba_pkg.sv
rtl/core/pba_req_if.sv
rtl/core/pba_rsp_if.sv
rtl/core/page_bitmap_next_fit_allocator_top.sv
test/tb.sv
